// File: rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types, codes and decode tables for the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    // chunk length field; covers a sysex store of up to 127 bytes
    localparam int LEN_W = 7;

    localparam logic [7:0] BYTE_RT_MIN = 8'hf8;
    localparam logic [7:0] BYTE_EOX    = 8'hf7;
    localparam logic [3:0] NIB_SYSTEM  = 4'hf;
    localparam logic [16:0] BEND_CENTER = 17'd8192;

    // running message codes
    localparam logic [3:0] MSG_NOTE_OFF   = 4'd0;
    localparam logic [3:0] MSG_KEY_PRESS  = 4'd2;
    localparam logic [3:0] MSG_CTRL       = 4'd3;
    localparam logic [3:0] MSG_PROGRAM    = 4'd4;
    localparam logic [3:0] MSG_CHAN_PRESS = 4'd5;
    localparam logic [3:0] MSG_BEND       = 4'd6;
    localparam logic [3:0] MSG_NONE       = 4'd7;
    localparam logic [3:0] MSG_SYSEX      = 4'd8;
    localparam logic [3:0] MSG_QFRAME     = 4'd9;
    localparam logic [3:0] MSG_SONG_POS   = 4'd10;
    localparam logic [3:0] MSG_SONG_SEL   = 4'd11;

    // result kinds
    localparam logic [4:0] KIND_NONE       = 5'd0;
    localparam logic [4:0] KIND_SYSEX      = 5'd8;
    localparam logic [4:0] KIND_QFRAME     = 5'd9;
    localparam logic [4:0] KIND_SONG_POS   = 5'd10;
    localparam logic [4:0] KIND_SONG_SEL   = 5'd11;
    localparam logic [4:0] KIND_TUNE_REQ   = 5'd12;
    localparam logic [4:0] KIND_CLOCK      = 5'd13;
    localparam logic [4:0] KIND_START      = 5'd14;
    localparam logic [4:0] KIND_CONTINUE   = 5'd15;
    localparam logic [4:0] KIND_STOP       = 5'd16;
    localparam logic [4:0] KIND_ACT_SENSE  = 5'd17;
    localparam logic [4:0] KIND_SYS_RESET  = 5'd18;

    typedef struct packed {
        logic             is_chunk;
        logic [4:0]       kind;
        logic [3:0]       channel;
        logic [7:0]       param;
        logic [16:0]      value;
        logic [LEN_W-1:0] length;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // kind of system status 0xf0..0xff, by low nibble
    function automatic logic [4:0] sys_kind(input logic [3:0] nib);
        logic [4:0] k;
        begin
            unique case (nib)
                4'h0:    k = KIND_SYSEX;
                4'h1:    k = KIND_QFRAME;
                4'h2:    k = KIND_SONG_POS;
                4'h3:    k = KIND_SONG_SEL;
                4'h6:    k = KIND_TUNE_REQ;
                4'h8:    k = KIND_CLOCK;
                4'ha:    k = KIND_START;
                4'hb:    k = KIND_CONTINUE;
                4'hc:    k = KIND_STOP;
                4'he:    k = KIND_ACT_SENSE;
                4'hf:    k = KIND_SYS_RESET;
                default: k = KIND_NONE;
            endcase
            return k;
        end
    endfunction

    // data bytes a running message needs
    function automatic logic [1:0] need_bytes(input logic [3:0] msg);
        logic [1:0] n;
        begin
            unique case (msg) inside
                [MSG_NOTE_OFF:MSG_CTRL], MSG_BEND, MSG_SONG_POS:
                    n = 2'd2;
                MSG_PROGRAM, MSG_CHAN_PRESS, MSG_SYSEX, MSG_QFRAME, MSG_SONG_SEL:
                    n = 2'd1;
                default:
                    n = 2'd0;
            endcase
            return n;
        end
    endfunction

    function automatic cmd_t make_msg(input logic [3:0] msg, input logic [7:0] b0,
                                      input logic [7:0] b1, input logic [7:0] b2);
        cmd_t       c;
        logic [16:0] wide;
        begin
            c = '0;
            wide = {2'b00, b2, 7'b0} + {9'b0, b1};
            if (msg < MSG_NONE)
                c.kind = {1'b0, msg} + 5'd1;
            else if (msg == MSG_NONE)
                c.kind = KIND_NONE;
            else
                c.kind = sys_kind({1'b0, msg[2:0]});
            unique case (msg) inside
                [MSG_NOTE_OFF:MSG_CTRL]:
                begin
                    c.channel = b0[3:0];
                    c.param   = b1;
                    c.value   = {9'b0, b2};
                end
                MSG_PROGRAM, MSG_CHAN_PRESS:
                begin
                    c.channel = b0[3:0];
                    c.value   = {9'b0, b1};
                end
                MSG_BEND:
                begin
                    c.channel = b0[3:0];
                    c.value   = wide - BEND_CENTER;
                end
                MSG_QFRAME, MSG_SONG_SEL:
                begin
                    c.value = {9'b0, b1};
                end
                MSG_SONG_POS:
                begin
                    c.value = wide;
                end
                default:
                begin
                    c.value = '0;
                end
            endcase
            return c;
        end
    endfunction

endpackage

// File: rtl/mbsp_front.sv
// ----------------------------------------------------------------------------
// mbsp_front
// Byte classifier: running status tracking, sysex store writes, commands.
// ----------------------------------------------------------------------------
module mbsp_front #(
    parameter int SYSEX_BUF = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      midi_byte,
    input  logic                            cfg_we,
    input  logic [5:0]                      cfg_data,
    input  logic                            q_full,
    output logic                            q_push,
    output mbsp_pkg::cmd_t                  q_cmd,
    input  logic                            chunk_done,
    output logic                            st_we,
    output logic [$clog2(SYSEX_BUF)-1:0]    st_addr,
    output logic [7:0]                      st_data
);

    localparam int CNT_W  = $clog2(SYSEX_BUF + 1);
    localparam int ADDR_W = $clog2(SYSEX_BUF);

    logic [5:0]       chunk_size_reg, chunk_size_next;
    logic [3:0]       msg_kind_reg, msg_kind_next;
    logic [1:0]       pend_reg, pend_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [7:0]       b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic             chunk_out_reg, chunk_out_next;

    logic             accept;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic [1:0]       pend_v;
    logic             no_res;
    logic [7:0]       limit8, fill8, size8;
    logic [4:0]       rt_kind;
    mbsp_pkg::cmd_t   cmd;

    assign in_stall = q_full | chunk_out_reg;
    assign accept   = in_valid & ~in_stall;
    assign st_data  = midi_byte;
    assign st_we    = wr_en;
    assign st_addr  = wr_idx[ADDR_W-1:0];
    assign q_cmd    = cmd;

    assign size8  = {2'b00, chunk_size_reg};
    assign limit8 = (size8 == 8'd0) ? 8'd1 :
                    (size8 > 8'(SYSEX_BUF)) ? 8'(SYSEX_BUF) : size8;

    always_comb
    begin
        chunk_size_next = cfg_we ? cfg_data : chunk_size_reg;
        msg_kind_next   = msg_kind_reg;
        pend_next       = pend_reg;
        fill_next       = fill_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        chunk_out_next  = chunk_out_reg & ~chunk_done;
        wr_en           = 1'b0;
        wr_idx          = '0;
        pend_v          = 2'd0;
        no_res          = 1'b0;
        rt_kind         = mbsp_pkg::KIND_NONE;
        fill8           = 8'd0;
        q_push          = 1'b0;
        cmd             = '0;
        if (accept)
        begin
            if (midi_byte >= mbsp_pkg::BYTE_RT_MIN)
            begin
                rt_kind  = mbsp_pkg::sys_kind(midi_byte[3:0]);
                cmd.kind = rt_kind;
                q_push   = (rt_kind != mbsp_pkg::KIND_NONE);
            end
            else
            begin
                if (pend_reg != 2'd0)
                begin
                    wr_en  = (fill_reg < CNT_W'(SYSEX_BUF));
                    wr_idx = fill_reg;
                    if (wr_en)
                        fill_next = fill_reg + CNT_W'(1);
                    pend_v = (msg_kind_reg == mbsp_pkg::MSG_SYSEX) ? pend_reg
                                                                   : pend_reg - 2'd1;
                end
                else if (midi_byte[7])
                begin
                    wr_en     = 1'b1;
                    wr_idx    = '0;
                    fill_next = CNT_W'(1);
                    msg_kind_next = (midi_byte[7:4] == mbsp_pkg::NIB_SYSTEM)
                                    ? {1'b1, midi_byte[2:0]} : {1'b0, midi_byte[6:4]};
                    pend_v = mbsp_pkg::need_bytes(msg_kind_next);
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_idx    = CNT_W'(1);
                    fill_next = CNT_W'(2);
                    if (mbsp_pkg::need_bytes(msg_kind_reg) == 2'd0)
                        no_res = 1'b1;
                    else
                        pend_v = mbsp_pkg::need_bytes(msg_kind_reg) - 2'd1;
                end
                pend_next = no_res ? 2'd0 : pend_v;

                if (wr_en && wr_idx == CNT_W'(0))
                    b0_next = midi_byte;
                if (wr_en && wr_idx == CNT_W'(1))
                    b1_next = midi_byte;
                if (wr_en && wr_idx == CNT_W'(2))
                    b2_next = midi_byte;

                fill8 = 8'(fill_next);
                if (!no_res && pend_v == 2'd0)
                begin
                    cmd    = mbsp_pkg::make_msg(msg_kind_next, b0_next, b1_next, b2_next);
                    q_push = (cmd.kind != mbsp_pkg::KIND_NONE);
                end
                else if (!no_res && msg_kind_next == mbsp_pkg::MSG_SYSEX)
                begin
                    if (midi_byte == mbsp_pkg::BYTE_EOX || fill8 >= limit8)
                    begin
                        q_push         = 1'b1;
                        cmd.is_chunk   = 1'b1;
                        cmd.kind       = mbsp_pkg::KIND_SYSEX;
                        cmd.length     = mbsp_pkg::LEN_W'(fill_next);
                        fill_next      = '0;
                        chunk_out_next = 1'b1;
                        if (midi_byte == mbsp_pkg::BYTE_EOX)
                        begin
                            msg_kind_next = mbsp_pkg::MSG_NOTE_OFF;
                            pend_next     = 2'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg <= 6'd32;
            msg_kind_reg   <= mbsp_pkg::MSG_NOTE_OFF;
            pend_reg       <= 2'd0;
            fill_reg       <= '0;
            b0_reg         <= 8'd0;
            b1_reg         <= 8'd0;
            b2_reg         <= 8'd0;
            chunk_out_reg  <= 1'b0;
        end
        else
        begin
            chunk_size_reg <= chunk_size_next;
            msg_kind_reg   <= msg_kind_next;
            pend_reg       <= pend_next;
            fill_reg       <= fill_next;
            b0_reg         <= b0_next;
            b1_reg         <= b1_next;
            b2_reg         <= b2_next;
            chunk_out_reg  <= chunk_out_next;
        end
    end

endmodule

// File: rtl/mbsp_queue.sv
// ----------------------------------------------------------------------------
// mbsp_queue
// Two-entry command queue between classifier and emitter.
// ----------------------------------------------------------------------------
module mbsp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mbsp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output mbsp_pkg::cmd_t head
);

    mbsp_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/mbsp_back.sv
// ----------------------------------------------------------------------------
// mbsp_back
// Result emitter: sysex store, chunk readout and output register.
// ----------------------------------------------------------------------------
module mbsp_back #(
    parameter int SYSEX_BUF = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  mbsp_pkg::cmd_t               q_cmd,
    output logic                         q_pop,
    output logic                         chunk_done,
    input  logic                         st_we,
    input  logic [$clog2(SYSEX_BUF)-1:0] st_addr,
    input  logic [7:0]                   st_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [4:0]                   event_kind,
    output logic [3:0]                   channel,
    output logic [7:0]                   param,
    output logic signed [16:0]           value,
    output logic [7:0]                   sysex_byte,
    output logic [5:0]                   sysex_length,
    output logic                         last
);

    localparam int ADDR_W = $clog2(SYSEX_BUF);
    localparam int LEN_W  = mbsp_pkg::LEN_W;

    logic [7:0]             store_mem [SYSEX_BUF];
    logic [7:0]             rd_q_reg;

    mbsp_pkg::back_state_t  state_reg, state_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [LEN_W-1:0]       len_reg, len_next;

    logic                   out_valid_reg, out_valid_next;
    logic [4:0]             kind_reg;
    logic [3:0]             chan_reg;
    logic [7:0]             param_reg;
    logic [16:0]            value_reg;
    logic [7:0]             sbyte_reg;
    logic [5:0]             slen_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   last_byte;
    logic                   load_msg;
    logic                   load_byte;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign last_byte = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbsp_pkg::BK_IDLE:
            begin
                if (q_valid && q_cmd.is_chunk)
                    state_next = mbsp_pkg::BK_READ;
            end
            mbsp_pkg::BK_READ:
            begin
                state_next = mbsp_pkg::BK_EMIT;
            end
            mbsp_pkg::BK_EMIT:
            begin
                if (out_free)
                    state_next = last_byte ? mbsp_pkg::BK_IDLE : mbsp_pkg::BK_READ;
            end
            default:
            begin
                state_next = mbsp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        load_msg   = 1'b0;
        load_byte  = 1'b0;
        chunk_done = 1'b0;
        idx_next   = idx_reg;
        len_next   = len_reg;
        unique case (state_reg)
            mbsp_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_chunk)
                    begin
                        q_pop    = 1'b1;
                        len_next = q_cmd.length;
                        idx_next = '0;
                    end
                    else if (out_free)
                    begin
                        q_pop    = 1'b1;
                        load_msg = 1'b1;
                    end
                end
            end
            mbsp_pkg::BK_READ:
            begin
                q_pop = 1'b0;
            end
            mbsp_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    load_byte = 1'b1;
                    if (last_byte)
                        chunk_done = 1'b1;
                    else
                        idx_next = idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_msg || load_byte)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_addr] <= st_data;
        rd_q_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_msg)
        begin
            kind_reg  <= q_cmd.kind;
            chan_reg  <= q_cmd.channel;
            param_reg <= q_cmd.param;
            value_reg <= q_cmd.value;
            sbyte_reg <= 8'd0;
            slen_reg  <= 6'd0;
            last_reg  <= 1'b1;
        end
        else if (load_byte)
        begin
            kind_reg  <= mbsp_pkg::KIND_SYSEX;
            chan_reg  <= 4'd0;
            param_reg <= 8'd0;
            value_reg <= 17'd0;
            sbyte_reg <= rd_q_reg;
            slen_reg  <= len_reg[5:0];
            last_reg  <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbsp_pkg::BK_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign channel      = chan_reg;
    assign param        = param_reg;
    assign value        = value_reg;
    assign sysex_byte   = sbyte_reg;
    assign sysex_length = slen_reg;
    assign last         = last_reg;

endmodule

// File: rtl/midi_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// MIDI byte parser with running status, real-time events and sysex chunking.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per cycle while the input is not stalled. A byte that
// completes a channel or system message, or a defined real-time byte, gives one
// result that is written into the queue and then loaded into the output register
// when the output is free; a two-entry queue sits between the byte classifier
// and the emitter, so input keeps flowing while a result waits, and stalls once
// the queue is full. A sysex chunk is read out of the sysex store one byte at a
// time, each byte through a registered store read and then an output load.
// Input is stalled from the transfer that closes the chunk until the last byte
// is loaded.
module midi_byte_stream_parser #(
    parameter int SYSEX_BUF = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         midi_byte,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         event_kind,
    output logic [3:0]         channel,
    output logic [7:0]         param,
    output logic signed [16:0] value,
    output logic [7:0]         sysex_byte,
    output logic [5:0]         sysex_length,
    output logic               last
);

    localparam int ADDR_W = $clog2(SYSEX_BUF);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    mbsp_pkg::cmd_t     push_cmd;
    mbsp_pkg::cmd_t     head_cmd;
    logic               chunk_done;
    logic               st_we;
    logic [ADDR_W-1:0]  st_addr;
    logic [7:0]         st_data;

    mbsp_front #(
        .SYSEX_BUF (SYSEX_BUF)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .midi_byte  (midi_byte),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .chunk_done (chunk_done),
        .st_we      (st_we),
        .st_addr    (st_addr),
        .st_data    (st_data)
    );

    mbsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    mbsp_back #(
        .SYSEX_BUF (SYSEX_BUF)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .chunk_done   (chunk_done),
        .st_we        (st_we),
        .st_addr      (st_addr),
        .st_data      (st_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .channel      (channel),
        .param        (param),
        .value        (value),
        .sysex_byte   (sysex_byte),
        .sysex_length (sysex_length),
        .last         (last)
    );

endmodule

// File: verif/mbsp_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbsp_tb_pkg
// Event record, status byte codes and the event scoreboard for the parser
// testbench. The scoreboard tracks running status, the sysex store and the
// chunk size register, and queues the events each accepted byte must produce.
// ----------------------------------------------------------------------------
package mbsp_tb_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int REPORT_MAX  = 10;

    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_KEY_PRESS  = 8'ha0;
    localparam logic [7:0] ST_CTRL       = 8'hb0;
    localparam logic [7:0] ST_PROGRAM    = 8'hc0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hd0;
    localparam logic [7:0] ST_BEND       = 8'he0;
    localparam logic [7:0] ST_EXCL       = 8'hf0;
    localparam logic [7:0] ST_QFRAME     = 8'hf1;
    localparam logic [7:0] ST_SONG_POS   = 8'hf2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hf3;
    localparam logic [7:0] ST_UNDEF_F4   = 8'hf4;
    localparam logic [7:0] ST_UNDEF_F5   = 8'hf5;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hf6;
    localparam logic [7:0] ST_EOX        = 8'hf7;
    localparam logic [7:0] ST_CLOCK      = 8'hf8;
    localparam logic [7:0] ST_UNDEF_F9   = 8'hf9;
    localparam logic [7:0] ST_START      = 8'hfa;
    localparam logic [7:0] ST_CONTINUE   = 8'hfb;
    localparam logic [7:0] ST_STOP       = 8'hfc;
    localparam logic [7:0] ST_UNDEF_FD   = 8'hfd;
    localparam logic [7:0] ST_ACT_SENSE  = 8'hfe;
    localparam logic [7:0] ST_SYS_RESET  = 8'hff;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  channel;
        logic [7:0]  param;
        logic [16:0] value;
        logic [7:0]  sbyte;
        logic [5:0]  slen;
        logic        last;
    } midi_event_t;

    class midi_event_sb;
        logic [5:0]  chunk_size;
        logic [3:0]  msg_kind;
        logic [1:0]  bytes_left;
        int          fill;
        logic [7:0]  store [STORE_DEPTH];
        midi_event_t pending_events[$];
        int          errors;

        function new();
            chunk_size = 6'd32;
            msg_kind   = mbsp_pkg::MSG_NOTE_OFF;
            bytes_left = 2'd0;
            fill       = 0;
            errors     = 0;
            foreach (store[i])
                store[i] = 8'h00;
        endfunction

        function void set_chunk_size(input logic [5:0] v);
            chunk_size = v;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function logic [4:0] status_kind(input logic [7:0] st);
            case (st)
                ST_EXCL:      return mbsp_pkg::KIND_SYSEX;
                ST_QFRAME:    return mbsp_pkg::KIND_QFRAME;
                ST_SONG_POS:  return mbsp_pkg::KIND_SONG_POS;
                ST_SONG_SEL:  return mbsp_pkg::KIND_SONG_SEL;
                ST_TUNE_REQ:  return mbsp_pkg::KIND_TUNE_REQ;
                ST_CLOCK:     return mbsp_pkg::KIND_CLOCK;
                ST_START:     return mbsp_pkg::KIND_START;
                ST_CONTINUE:  return mbsp_pkg::KIND_CONTINUE;
                ST_STOP:      return mbsp_pkg::KIND_STOP;
                ST_ACT_SENSE: return mbsp_pkg::KIND_ACT_SENSE;
                ST_SYS_RESET: return mbsp_pkg::KIND_SYS_RESET;
                default:      return mbsp_pkg::KIND_NONE;
            endcase
        endfunction

        function logic [1:0] data_needed(input logic [3:0] m);
            if (m <= mbsp_pkg::MSG_CTRL || m == mbsp_pkg::MSG_BEND ||
                m == mbsp_pkg::MSG_SONG_POS)
                return 2'd2;
            if (m == mbsp_pkg::MSG_PROGRAM || m == mbsp_pkg::MSG_CHAN_PRESS ||
                m == mbsp_pkg::MSG_SYSEX || m == mbsp_pkg::MSG_QFRAME ||
                m == mbsp_pkg::MSG_SONG_SEL)
                return 2'd1;
            return 2'd0;
        endfunction

        function string fmt_event(input midi_event_t e);
            return $sformatf("kind=%0d ch=%0d param=%0d value=%0d byte=%h len=%0d last=%b",
                             e.kind, e.channel, e.param, $signed(e.value),
                             e.sbyte, e.slen, e.last);
        endfunction

        function void add_event(input logic [4:0] kind, input logic [3:0] ch,
                                input logic [7:0] prm, input logic [16:0] val,
                                input logic [7:0] sb, input logic [5:0] len,
                                input logic lst);
            midi_event_t e;
            e.kind    = kind;
            e.channel = ch;
            e.param   = prm;
            e.value   = val;
            e.sbyte   = sb;
            e.slen    = len;
            e.last    = lst;
            pending_events.push_back(e);
        endfunction

        // completed channel or system common message
        function void add_message();
            logic [4:0] kind;
            logic [3:0] ch;
            int         wide;
            wide = int'(store[2]) * 128 + int'(store[1]);
            ch   = store[0][3:0];
            if (msg_kind < mbsp_pkg::MSG_NONE)
                kind = 5'(msg_kind) + 5'd1;
            else if (msg_kind == mbsp_pkg::MSG_NONE)
                kind = mbsp_pkg::KIND_NONE;
            else
                kind = status_kind(ST_EXCL + 8'(msg_kind - mbsp_pkg::MSG_SYSEX));
            if (kind == mbsp_pkg::KIND_NONE)
                return;
            if (msg_kind <= mbsp_pkg::MSG_CTRL)
                add_event(kind, ch, store[1], 17'(store[2]), 8'h00, 6'd0, 1'b1);
            else if (msg_kind == mbsp_pkg::MSG_PROGRAM ||
                     msg_kind == mbsp_pkg::MSG_CHAN_PRESS)
                add_event(kind, ch, 8'h00, 17'(store[1]), 8'h00, 6'd0, 1'b1);
            else if (msg_kind == mbsp_pkg::MSG_BEND)
                add_event(kind, ch, 8'h00, 17'(wide - int'(mbsp_pkg::BEND_CENTER)),
                          8'h00, 6'd0, 1'b1);
            else if (msg_kind == mbsp_pkg::MSG_QFRAME ||
                     msg_kind == mbsp_pkg::MSG_SONG_SEL)
                add_event(kind, 4'h0, 8'h00, 17'(store[1]), 8'h00, 6'd0, 1'b1);
            else if (msg_kind == mbsp_pkg::MSG_SONG_POS)
                add_event(kind, 4'h0, 8'h00, 17'(wide), 8'h00, 6'd0, 1'b1);
            else
                add_event(kind, 4'h0, 8'h00, 17'h0, 8'h00, 6'd0, 1'b1);
        endfunction

        // one accepted input transfer
        function void take_byte(input logic [7:0] c);
            int pend;
            int limit;
            if (c >= mbsp_pkg::BYTE_RT_MIN)
            begin
                if (status_kind(c) != mbsp_pkg::KIND_NONE)
                    add_event(status_kind(c), 4'h0, 8'h00, 17'h0, 8'h00, 6'd0, 1'b1);
                return;
            end
            if (bytes_left != 2'd0)
            begin
                if (fill < STORE_DEPTH)
                begin
                    store[fill] = c;
                    fill++;
                end
                pend = int'(bytes_left);
                if (msg_kind != mbsp_pkg::MSG_SYSEX)
                    pend--;
            end
            else if (c[7])
            begin
                fill     = 1;
                store[0] = c;
                msg_kind = (c[7:4] == mbsp_pkg::NIB_SYSTEM) ?
                           mbsp_pkg::MSG_SYSEX + 4'(c[2:0]) : {1'b0, c[6:4]};
                pend     = int'(data_needed(msg_kind));
            end
            else
            begin
                store[1] = c;
                fill     = 2;
                pend     = int'(data_needed(msg_kind)) - 1;
            end
            bytes_left = (pend < 0) ? 2'd0 : 2'(pend);
            if (pend == 0)
            begin
                add_message();
                return;
            end
            if (pend > 0 && msg_kind == mbsp_pkg::MSG_SYSEX)
            begin
                limit = int'(chunk_size);
                if (limit < 1)
                    limit = 1;
                if (limit > STORE_DEPTH)
                    limit = STORE_DEPTH;
                if (c == mbsp_pkg::BYTE_EOX || fill >= limit)
                begin
                    for (int i = 0; i < fill; i++)
                        add_event(mbsp_pkg::KIND_SYSEX, 4'h0, 8'h00, 17'h0, store[i],
                                  6'(fill), i == fill - 1);
                    fill = 0;
                    if (c == mbsp_pkg::BYTE_EOX)
                    begin
                        msg_kind   = mbsp_pkg::MSG_NOTE_OFF;
                        bytes_left = 2'd0;
                    end
                end
            end
        endfunction

        // one accepted output transfer
        function void match_event(input midi_event_t got);
            midi_event_t want;
            bit          bad;
            if (pending_events.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected event: %s", fmt_event(got));
                return;
            end
            want = pending_events.pop_front();
            bad = (got.kind !== want.kind) || (got.channel !== want.channel) ||
                  (got.param !== want.param) || (got.value !== want.value) ||
                  (got.sbyte !== want.sbyte) || (got.slen !== want.slen) ||
                  (got.last !== want.last);
            if (bad)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("event mismatch:");
                    $display("  exp %s", fmt_event(want));
                    $display("  got %s", fmt_event(got));
                end
            end
        endfunction
    endclass

endpackage

// File: verif/midi_byte_stream_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_tb
// Feeds directed and random MIDI byte streams through the parser under several
// chunk sizes and flow-control patterns, including a long output hold-off, and
// checks every event against the scoreboard's running-status model.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_tb;

    localparam int HALF_PERIOD    = 4;
    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_PHASE     = 4;

    localparam logic [5:0] CHUNK_PLAN [PHASES] = '{
        6'd1, 6'd0, 6'd63, 6'd5, 6'd32, 6'd2, 6'd33, 6'd17
    };

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         midi_byte;
    logic               cfg_we;
    logic [5:0]         cfg_data;
    logic               out_valid;
    logic               out_stall;
    logic [4:0]         event_kind;
    logic [3:0]         channel;
    logic [7:0]         param;
    logic signed [16:0] value;
    logic [7:0]         sysex_byte;
    logic [5:0]         sysex_length;
    logic               last;

    mbsp_tb_pkg::midi_event_sb events = new();
    logic [7:0]   stim_q[$];
    idle_mode_t   idle_mode = IDLE_NONE;
    bit           hold_req  = 1'b0;
    int           watchdog  = 0;

    midi_byte_stream_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .midi_byte    (midi_byte),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .channel      (channel),
        .param        (param),
        .value        (value),
        .sysex_byte   (sysex_byte),
        .sysex_length (sysex_length),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 66;
            IDLE_BOTH: return $urandom_range(0, 99) < 18;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 66;
            IDLE_BOTH: return $urandom_range(0, 99) < 18;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 99) < 8)
            return 8'($urandom_range(8'h80, 8'hf6));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] realtime_byte();
        return 8'($urandom_range(mbsp_tb_pkg::ST_CLOCK, mbsp_tb_pkg::ST_SYS_RESET));
    endfunction

    // mostly well-formed messages with random content, some noise
    task automatic gen_message();
        int         sel;
        int         n;
        logic [7:0] st;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            case ($urandom_range(0, 6))
                0:       st = mbsp_tb_pkg::ST_NOTE_OFF;
                1:       st = mbsp_tb_pkg::ST_NOTE_ON;
                2:       st = mbsp_tb_pkg::ST_KEY_PRESS;
                3:       st = mbsp_tb_pkg::ST_CTRL;
                4:       st = mbsp_tb_pkg::ST_PROGRAM;
                5:       st = mbsp_tb_pkg::ST_CHAN_PRESS;
                default: st = mbsp_tb_pkg::ST_BEND;
            endcase
            n = (st == mbsp_tb_pkg::ST_PROGRAM || st == mbsp_tb_pkg::ST_CHAN_PRESS) ? 1 : 2;
            if ($urandom_range(0, 99) < 85)
                stim_q.push_back(st | 8'($urandom_range(0, 15)));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    stim_q.push_back(realtime_byte());
                stim_q.push_back(data_byte());
            end
        end
        else if (sel < 62)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    st = mbsp_tb_pkg::ST_QFRAME;
                    n  = 1;
                end
                1:
                begin
                    st = mbsp_tb_pkg::ST_SONG_POS;
                    n  = 2;
                end
                2:
                begin
                    st = mbsp_tb_pkg::ST_SONG_SEL;
                    n  = 1;
                end
                default:
                begin
                    st = mbsp_tb_pkg::ST_TUNE_REQ;
                    n  = 0;
                end
            endcase
            if (n == 0 || $urandom_range(0, 99) < 85)
                stim_q.push_back(st);
            for (int i = 0; i < n; i++)
                stim_q.push_back(data_byte());
        end
        else if (sel < 72)
        begin
            stim_q.push_back(realtime_byte());
        end
        else if (sel < 88)
        begin
            stim_q.push_back(mbsp_tb_pkg::ST_EXCL);
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 40);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 5)
                    stim_q.push_back(realtime_byte());
                if ($urandom_range(0, 99) < 92)
                    stim_q.push_back(8'($urandom_range(0, 127)));
                else
                    stim_q.push_back(8'($urandom_range(8'h80, 8'hf6)));
            end
            if ($urandom_range(0, 99) < 90)
                stim_q.push_back(mbsp_tb_pkg::ST_EOX);
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            stim_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       stim_q.push_back(mbsp_tb_pkg::ST_UNDEF_F4);
                1:       stim_q.push_back(mbsp_tb_pkg::ST_UNDEF_F5);
                default: stim_q.push_back(mbsp_tb_pkg::ST_EOX);
            endcase
            stim_q.push_back(8'($urandom_range(0, 127)));
        end
    endtask

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        midi_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        events.take_byte(b);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (events.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_chunk(input logic [5:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        events.set_chunk_size(v);
    endtask

    // output side
    initial
    begin
        mbsp_tb_pkg::midi_event_t got;
        int                       hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.kind    = event_kind;
                got.channel = channel;
                got.param   = param;
                got.value   = value;
                got.sbyte   = sysex_byte;
                got.slen    = sysex_length;
                got.last    = last;
                events.match_event(got);
            end
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= receiver_stalls();
            end
        end
    end

    // no transfer on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            watchdog <= 0;
        end
        else if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            watchdog <= watchdog + 1;
        end
    end

    initial
    begin
        logic [7:0] opening[$];
        int         sent;
        in_valid  = 1'b0;
        midi_byte = 8'h00;
        cfg_we    = 1'b0;
        cfg_data  = 6'd0;
        rst_n     = 1'b0;

        opening = '{
            mbsp_tb_pkg::ST_NOTE_ON | 8'h0f, 8'h00, mbsp_tb_pkg::ST_SYS_RESET, 8'h80,
            8'h7f, 8'h7f,
            mbsp_tb_pkg::ST_NOTE_OFF | 8'h02, 8'hff, 8'h00,
            mbsp_tb_pkg::ST_KEY_PRESS | 8'h01, 8'h11, 8'h22,
            mbsp_tb_pkg::ST_CTRL | 8'h03, 8'h07, 8'h64,
            mbsp_tb_pkg::ST_PROGRAM | 8'h02, 8'h05, 8'h55,
            mbsp_tb_pkg::ST_CHAN_PRESS | 8'h01, 8'hfe,
            mbsp_tb_pkg::ST_BEND, 8'h00, 8'h00,
            mbsp_tb_pkg::ST_BEND | 8'h05, 8'hff, 8'hff,
            mbsp_tb_pkg::ST_QFRAME, 8'h3a, 8'h11,
            mbsp_tb_pkg::ST_SONG_POS, 8'hff, 8'hff,
            mbsp_tb_pkg::ST_SONG_SEL, 8'h05,
            mbsp_tb_pkg::ST_TUNE_REQ, 8'h40,
            mbsp_tb_pkg::ST_UNDEF_F4, 8'h01, mbsp_tb_pkg::ST_UNDEF_F5,
            mbsp_tb_pkg::ST_EOX, 8'h03,
            mbsp_tb_pkg::ST_CLOCK, mbsp_tb_pkg::ST_UNDEF_F9, mbsp_tb_pkg::ST_START,
            mbsp_tb_pkg::ST_CONTINUE, mbsp_tb_pkg::ST_STOP, mbsp_tb_pkg::ST_UNDEF_FD,
            mbsp_tb_pkg::ST_ACT_SENSE,
            mbsp_tb_pkg::ST_EXCL, 8'h01, mbsp_tb_pkg::ST_EOX,
            // left open so the next chunk size write lands mid-sysex
            mbsp_tb_pkg::ST_EXCL, 8'h01, 8'h02
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_byte(opening[i]);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_chunk(CHUNK_PLAN[ph]);
            idle_mode = idle_mode_t'(ph % 4);
            if (ph == HOLD_PHASE)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                gen_message();
                while (stim_q.size() != 0)
                begin
                    send_byte(stim_q.pop_front());
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (events.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (events.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
